/* src/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// Used by the core, the block table memory and the checker.
package ffba_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned SIZE_W         = 27;
  localparam int unsigned CNT_OUT_W      = 11;
  localparam int unsigned DEF_MAX_BLOCKS = 64;
  localparam int unsigned DEF_META_BYTES = 32;

  localparam logic [SIZE_W-1:0] SIZE_CAP       = SIZE_W'(100000000);
  localparam logic [DATA_W-1:0] HEAP_BASE_RST  = 32'h1000_0000;
  localparam logic [DATA_W-1:0] HEAP_LIMIT_RST = 32'h2000_0000;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_CALLOC  = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_REALLOC = 2'd3;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  // One block table entry: header address, payload size, free flag.
  typedef struct packed {
    logic [DATA_W-1:0] hdr;
    logic [SIZE_W-1:0] size;
    logic              free;
  } blk_t;

endpackage

/* src/ffba_table.sv */
// Block table storage: one write port and one read port, registered read data.
// Depends on ffba_pkg for the entry type.
module ffba_table #(
  parameter int unsigned MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned IW         = $clog2(MAX_BLOCKS)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  ffba_pkg::blk_t wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output ffba_pkg::blk_t rdata_o
);
  import ffba_pkg::*;

  blk_t mem_q [MAX_BLOCKS];
  blk_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/first_fit_block_allocator_core.sv */
// First-fit heap allocator core: control sequencer, statistics and config registers.
// Depends on ffba_pkg and instantiates ffba_table for the block table.
//
//   channel | direction | handshake              | word
//   in      | to core   | in_valid_i / in_stall_o  | opcode, req_size, elem_count, old_address
//   out     | from core | out_valid_o / out_stall_i| ret_address, ok, five counters
//   cfg     | to core   | cfg_valid_i / cfg_ready_o| cfg_index, cfg_data
//
// A new word is taken only in the idle state, once the last result is loaded for output; the
// block table is scanned one entry per cycle, twice for a realloc that moves.
// Reset is asynchronous; the table holds no valid bits and needs no clearing pass.
// A result waiting under out_stall_i holds the core in its last step until taken.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned META_BYTES = ffba_pkg::DEF_META_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic [ffba_pkg::DATA_W-1:0]       req_size_i,
  input  logic [ffba_pkg::DATA_W-1:0]       elem_count_i,
  input  logic [ffba_pkg::DATA_W-1:0]       old_address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ffba_pkg::DATA_W-1:0]       ret_address_o,
  output logic                              ok_o,
  output logic [ffba_pkg::CNT_OUT_W-1:0]    num_free_blocks_o,
  output logic [ffba_pkg::DATA_W-1:0]       num_free_bytes_o,
  output logic [ffba_pkg::CNT_OUT_W-1:0]    num_alloc_blocks_o,
  output logic [ffba_pkg::DATA_W-1:0]       num_alloc_bytes_o,
  output logic [ffba_pkg::DATA_W-1:0]       num_meta_bytes_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [ffba_pkg::DATA_W-1:0]       cfg_data_i
);
  import ffba_pkg::*;

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [DATA_W-1:0] META32 = DATA_W'(META_BYTES);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL      = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_HIT      = 3'd4;
  localparam logic [2:0] S_APPEND   = 3'd5;
  localparam logic [2:0] S_FREE_OLD = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [1:0]        op_q;
  logic [DATA_W-1:0] size_in_q, cnt_in_q, old_q;
  logic [63:0]       prod_q, prod_d;
  logic [SIZE_W-1:0] req_q, req_d;
  logic              lookup_q, lookup_d;     // scan matches by address, else by fit
  logic              move_q, move_d;         // realloc must free the old block after alloc
  logic [CW-1:0]     scan_idx_q, scan_idx_d;
  logic              chk_valid_q, chk_valid_d;
  logic [IW-1:0]     chk_idx_q, chk_idx_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d, old_idx_q, old_idx_d;
  blk_t              hit_ent_q, hit_ent_d, old_ent_q, old_ent_d;
  logic [DATA_W-1:0] ret_q, ret_d;
  logic              ok_q, ok_d;

  logic [DATA_W-1:0] heap_base_q, heap_limit_q, heap_top_q, heap_top_d;
  logic [CW-1:0]     blk_cnt_q, blk_cnt_d, free_cnt_q, free_cnt_d;
  logic [DATA_W-1:0] free_tot_q, free_tot_d, alloc_bytes_q, alloc_bytes_d;
  logic [DATA_W-1:0] meta_bytes_q, meta_bytes_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_ret_q, out_free_tot_q, out_alloc_bytes_q, out_meta_bytes_q;
  logic              out_ok_q;
  logic [CW-1:0]     out_free_cnt_q, out_blk_cnt_q;
  logic              out_load;

  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  blk_t          wdata, rdata;

  logic              size_bad, hit;
  logic [DATA_W-1:0] app_hdr;
  logic [DATA_W:0]   app_end;

  ffba_table #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .IW        (IW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign size_bad = (prod_q == 64'd0) || (prod_q > 64'(SIZE_CAP));
  assign hit = chk_valid_q &&
               (lookup_q ? ((rdata.hdr + META32) == old_q)
                         : (rdata.free && (rdata.size >= req_q)));
  assign app_hdr = (blk_cnt_q == '0) ? heap_base_q : heap_top_q;
  assign app_end = {1'b0, app_hdr} + {1'b0, META32} + (DATA_W + 1)'(req_q);

  always_comb begin
    state_d       = state_q;
    prod_d        = prod_q;
    req_d         = req_q;
    lookup_d      = lookup_q;
    move_d        = move_q;
    scan_idx_d    = scan_idx_q;
    chk_valid_d   = 1'b0;
    chk_idx_d     = chk_idx_q;
    hit_idx_d     = hit_idx_q;
    hit_ent_d     = hit_ent_q;
    old_idx_d     = old_idx_q;
    old_ent_d     = old_ent_q;
    ret_d         = ret_q;
    ok_d          = ok_q;
    heap_top_d    = heap_top_q;
    blk_cnt_d     = blk_cnt_q;
    free_cnt_d    = free_cnt_q;
    free_tot_d    = free_tot_q;
    alloc_bytes_d = alloc_bytes_q;
    meta_bytes_d  = meta_bytes_q;
    we            = 1'b0;
    waddr         = hit_idx_q;
    wdata         = hit_ent_q;
    re            = 1'b0;
    raddr         = scan_idx_q[IW-1:0];
    out_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (op_q == OP_CALLOC) begin
          prod_d = 64'(cnt_in_q) * 64'(size_in_q);
        end else begin
          prod_d = 64'(size_in_q);
        end
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        req_d      = prod_q[SIZE_W-1:0];
        move_d     = 1'b0;
        scan_idx_d = '0;
        ret_d      = '0;
        ok_d       = 1'b0;
        state_d    = S_SCAN;
        case (op_q)
          OP_FREE: begin
            lookup_d = 1'b1;
            if (old_q == '0) begin
              ok_d    = 1'b1;
              state_d = S_DONE;
            end
          end
          OP_REALLOC: begin
            lookup_d = (old_q != '0);
            if (size_bad) begin
              state_d = S_DONE;
            end
          end
          default: begin
            lookup_d = 1'b0;
            if (size_bad) begin
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_SCAN: begin
        // Reads are issued one entry per cycle; the read data is compared in the next cycle.
        if (scan_idx_q < blk_cnt_q) begin
          re          = 1'b1;
          scan_idx_d  = scan_idx_q + 1'b1;
          chk_valid_d = 1'b1;
          chk_idx_d   = scan_idx_q[IW-1:0];
        end
        if (hit) begin
          chk_valid_d = 1'b0;
          hit_idx_d   = chk_idx_q;
          hit_ent_d   = rdata;
          state_d     = S_HIT;
        end else if (!chk_valid_q && !(scan_idx_q < blk_cnt_q)) begin
          if (!lookup_q) begin
            state_d = S_APPEND;
          end else begin
            ok_d    = (op_q == OP_FREE);
            state_d = S_DONE;
          end
        end
      end
      S_HIT: begin
        state_d = S_DONE;
        if (!lookup_q) begin
          we           = 1'b1;
          wdata.free   = 1'b0;
          free_cnt_d   = free_cnt_q - 1'b1;
          free_tot_d   = free_tot_q - DATA_W'(hit_ent_q.size);
          ret_d        = hit_ent_q.hdr + META32;
          ok_d         = 1'b1;
          if (move_q) begin
            state_d = S_FREE_OLD;
          end
        end else if (op_q == OP_FREE) begin
          ok_d = 1'b1;
          if (!hit_ent_q.free) begin
            we           = 1'b1;
            wdata.free   = 1'b1;
            free_cnt_d   = free_cnt_q + 1'b1;
            free_tot_d   = free_tot_q + DATA_W'(hit_ent_q.size);
          end
        end else if (hit_ent_q.size >= req_q) begin
          ret_d = old_q;
          ok_d  = 1'b1;
        end else begin
          // Realloc moves: look for a new block, then free this one.
          old_idx_d  = hit_idx_q;
          old_ent_d  = hit_ent_q;
          move_d     = 1'b1;
          lookup_d   = 1'b0;
          scan_idx_d = '0;
          state_d    = S_SCAN;
        end
      end
      S_APPEND: begin
        state_d = S_DONE;
        if ((blk_cnt_q != FULL_CNT) && (app_end <= {1'b0, heap_limit_q})) begin
          we            = 1'b1;
          waddr         = blk_cnt_q[IW-1:0];
          wdata.hdr     = app_hdr;
          wdata.size    = req_q;
          wdata.free    = 1'b0;
          blk_cnt_d     = blk_cnt_q + 1'b1;
          heap_top_d    = app_end[DATA_W-1:0];
          alloc_bytes_d = alloc_bytes_q + DATA_W'(req_q);
          meta_bytes_d  = meta_bytes_q + META32;
          ret_d         = app_hdr + META32;
          ok_d          = 1'b1;
          if (move_q) begin
            state_d = S_FREE_OLD;
          end
        end
      end
      S_FREE_OLD: begin
        waddr = old_idx_q;
        wdata = old_ent_q;
        if (!old_ent_q.free) begin
          we           = 1'b1;
          wdata.free   = 1'b1;
          free_cnt_d   = free_cnt_q + 1'b1;
          free_tot_d   = free_tot_q + DATA_W'(old_ent_q.size);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chk_valid_q   <= 1'b0;
      heap_base_q   <= HEAP_BASE_RST;
      heap_limit_q  <= HEAP_LIMIT_RST;
      heap_top_q    <= HEAP_BASE_RST;
      blk_cnt_q     <= '0;
      free_cnt_q    <= '0;
      free_tot_q    <= '0;
      alloc_bytes_q <= '0;
      meta_bytes_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      chk_valid_q   <= chk_valid_d;
      heap_top_q    <= heap_top_d;
      blk_cnt_q     <= blk_cnt_d;
      free_cnt_q    <= free_cnt_d;
      free_tot_q    <= free_tot_d;
      alloc_bytes_q <= alloc_bytes_d;
      meta_bytes_q  <= meta_bytes_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_HEAP_BASE) begin
          heap_base_q <= cfg_data_i;
        end else begin
          heap_limit_q <= cfg_data_i;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q      <= opcode_i;
      size_in_q <= req_size_i;
      cnt_in_q  <= elem_count_i;
      old_q     <= old_address_i;
    end
    prod_q     <= prod_d;
    req_q      <= req_d;
    lookup_q   <= lookup_d;
    move_q     <= move_d;
    scan_idx_q <= scan_idx_d;
    chk_idx_q  <= chk_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_ent_q  <= hit_ent_d;
    old_idx_q  <= old_idx_d;
    old_ent_q  <= old_ent_d;
    ret_q      <= ret_d;
    ok_q       <= ok_d;
    if (out_load) begin
      out_ret_q         <= ret_q;
      out_ok_q          <= ok_q;
      out_free_cnt_q    <= free_cnt_q;
      out_free_tot_q    <= free_tot_q;
      out_blk_cnt_q     <= blk_cnt_q;
      out_alloc_bytes_q <= alloc_bytes_q;
      out_meta_bytes_q  <= meta_bytes_q;
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign ret_address_o      = out_ret_q;
  assign ok_o               = out_ok_q;
  assign num_free_blocks_o  = CNT_OUT_W'(out_free_cnt_q);
  assign num_free_bytes_o   = out_free_tot_q;
  assign num_alloc_blocks_o = CNT_OUT_W'(out_blk_cnt_q);
  assign num_alloc_bytes_o  = out_alloc_bytes_q;
  assign num_meta_bytes_o   = out_meta_bytes_q;

endmodule

/* src/ffba_checker.sv */
// Port-level checks for the first-fit allocator core, attached by bind.
// Depends on ffba_pkg for field widths.
module ffba_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ffba_pkg::DATA_W-1:0]    ret_address_o,
  input logic                           ok_o,
  input logic [ffba_pkg::CNT_OUT_W-1:0] num_free_blocks_o,
  input logic [ffba_pkg::CNT_OUT_W-1:0] num_alloc_blocks_o
);
  import ffba_pkg::*;

  // A word just taken keeps the core busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("core took two words back to back");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(ret_address_o)))
    else $error("stalled result word changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (num_free_blocks_o <= num_alloc_blocks_o))
    else $error("more free blocks than blocks");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (ret_address_o == '0))
    else $error("failed request returned an address");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .ret_address_o     (ret_address_o),
  .ok_o              (ok_o),
  .num_free_blocks_o (num_free_blocks_o),
  .num_alloc_blocks_o(num_alloc_blocks_o)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_block_allocator_core.
// Depends on ffba_pkg; predicts every result word with its own heap table model.
module tb;
  import ffba_pkg::*;

  localparam int unsigned NBLK = DEF_MAX_BLOCKS;
  localparam int unsigned HDR_BYTES = DEF_META_BYTES;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] ret;
    logic        ok;
    logic [10:0] fblk;
    logic [31:0] fbytes;
    logic [10:0] ablk;
    logic [31:0] abytes;
    logic [31:0] mbytes;
  } heap_result_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] opcode_i;
  logic [31:0] req_size_i, elem_count_i, old_address_i;
  logic out_valid_o, out_stall_i;
  logic [31:0] ret_address_o, num_free_bytes_o, num_alloc_bytes_o, num_meta_bytes_o;
  logic ok_o;
  logic [10:0] num_free_blocks_o, num_alloc_blocks_o;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [31:0] cfg_data_i;

  first_fit_block_allocator_core i_dut (.*);

  // Predictor state.
  logic [31:0] blk_hdr [NBLK];
  logic [31:0] blk_size [NBLK];
  logic        blk_free [NBLK];
  int unsigned n_blocks, n_free;
  logic [31:0] top_addr, free_total, alloc_bytes, meta_bytes, base_reg, limit_reg;

  heap_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit rx_random_stall, tx_random_gap, hold_rx;
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] heap_alloc(logic [63:0] sz);
    logic [63:0] hdr, fin;
    if (sz == 0 || sz > 64'd100000000) return 0;
    for (int i = 0; i < n_blocks; i++) begin
      if (blk_free[i] && {32'd0, blk_size[i]} >= sz) begin
        blk_free[i] = 1'b0;
        n_free--;
        free_total -= blk_size[i];
        return blk_hdr[i] + HDR_BYTES;
      end
    end
    if (n_blocks >= NBLK) return 0;
    hdr = (n_blocks == 0) ? {32'd0, base_reg} : {32'd0, top_addr};
    fin = hdr + HDR_BYTES + sz;
    if (fin > {32'd0, limit_reg}) return 0;
    blk_hdr[n_blocks] = hdr[31:0];
    blk_size[n_blocks] = sz[31:0];
    blk_free[n_blocks] = 1'b0;
    n_blocks++;
    top_addr = fin[31:0];
    alloc_bytes += sz[31:0];
    meta_bytes += HDR_BYTES;
    return hdr[31:0] + HDR_BYTES;
  endfunction

  function automatic int lookup_block(logic [31:0] addr);
    for (int i = 0; i < n_blocks; i++)
      if (blk_hdr[i] + HDR_BYTES == addr) return i;
    return -1;
  endfunction

  function automatic void heap_release(logic [31:0] addr);
    int k;
    if (addr == 0) return;
    k = lookup_block(addr);
    if (k < 0 || blk_free[k]) return;
    blk_free[k] = 1'b1;
    n_free++;
    free_total += blk_size[k];
  endfunction

  function automatic heap_result_t heap_request(logic [1:0] op, logic [31:0] sz,
                                                logic [31:0] cnt, logic [31:0] old);
    heap_result_t r;
    int k;
    r = '0;
    case (op)
      OP_ALLOC: r.ret = heap_alloc({32'd0, sz});
      OP_CALLOC: r.ret = heap_alloc({32'd0, cnt} * {32'd0, sz});
      OP_FREE: heap_release(old);
      default: begin
        if (sz == 0 || sz > 32'd100000000) r.ret = 0;
        else if (old == 0) r.ret = heap_alloc({32'd0, sz});
        else begin
          k = lookup_block(old);
          if (k < 0) r.ret = 0;
          else if (blk_size[k] >= sz) r.ret = old;
          else begin
            r.ret = heap_alloc({32'd0, sz});
            if (r.ret != 0) heap_release(old);
          end
        end
      end
    endcase
    r.ok = (op == OP_FREE) ? 1'b1 : (r.ret != 0);
    r.fblk = n_free[10:0];
    r.fbytes = free_total;
    r.ablk = n_blocks[10:0];
    r.abytes = alloc_bytes;
    r.mbytes = meta_bytes;
    return r;
  endfunction

  // Valid stays high after a word is taken so that the next word can follow at once;
  // it drops only for an idle gap or when the sender waits for the results.
  task automatic send_request(logic [1:0] op, logic [31:0] sz, logic [31:0] cnt,
                              logic [31:0] old);
    int unsigned gap;
    if (tx_random_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    req_size_i <= sz;
    elem_count_i <= cnt;
    old_address_i <= old;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(heap_request(op, sz, cnt, old));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * NBLK + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_HEAP_BASE) begin
      base_reg = val;
      if (n_blocks == 0) top_addr = val;
    end else begin
      limit_reg = val;
    end
    @(posedge clk_i);
  endtask

  // Picks a payload address that the heap actually handed out, most of the time.
  function automatic logic [31:0] pick_address();
    if (n_blocks != 0 && $urandom_range(0, 9) < 8)
      return blk_hdr[$urandom_range(0, n_blocks - 1)] + HDR_BYTES;
    return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom;
      2: return 32'd100000000 + $urandom_range(0, 1);
      3: return $urandom_range(1, 1 << 20);
      default: return $urandom_range(1, 512);
    endcase
  endfunction

  task automatic test_directed();
    send_request(OP_ALLOC, 0, 0, 0);
    send_request(OP_ALLOC, 32'd100000001, 0, 0);
    send_request(OP_ALLOC, 32'd100000000, 0, 0);
    send_request(OP_ALLOC, 1, 0, 0);
    send_request(OP_ALLOC, 64, 0, 0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, 0, 0);
    send_request(OP_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(OP_CALLOC, 32'h0001_0000, 32'h0001_0000, 0);
    send_request(OP_CALLOC, 16, 4, 0);
    send_request(OP_CALLOC, 16, 0, 0);
    send_request(OP_FREE, 0, 0, 0);
    send_request(OP_FREE, 0, 0, 32'hDEAD_BEEF);
    send_request(OP_FREE, 0, 0, base_reg + 2 * HDR_BYTES + 100000000);
    send_request(OP_FREE, 0, 0, base_reg + 2 * HDR_BYTES + 100000000);
    send_request(OP_ALLOC, 2, 0, 0);
    send_request(OP_REALLOC, 0, 0, base_reg + HDR_BYTES);
    send_request(OP_REALLOC, 32'hFFFF_FFFF, 0, base_reg + HDR_BYTES);
    send_request(OP_REALLOC, 8, 0, 0);
    send_request(OP_REALLOC, 4, 0, 32'h0000_1234);
    send_request(OP_REALLOC, 1, 0, base_reg + HDR_BYTES);
    send_request(OP_REALLOC, 200, 0, base_reg + HDR_BYTES);
    send_request(OP_REALLOC, 32'd100000000, 0, base_reg + HDR_BYTES);
    wait_drained();
  endtask

  task automatic test_limits();
    // A tight limit makes growth fail; a zero limit makes every growth fail.
    write_reg(REG_HEAP_LIMIT, top_addr + HDR_BYTES + 40);
    send_request(OP_ALLOC, 41, 0, 0);
    send_request(OP_ALLOC, 40, 0, 0);
    send_request(OP_ALLOC, 1, 0, 0);
    wait_drained();
    write_reg(REG_HEAP_LIMIT, 32'd0);
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 1, 0, 0);
    wait_drained();
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_BASE, 32'd0);
    wait_drained();
  endtask

  task automatic test_fill_table();
    for (int i = 0; i < NBLK + 4; i++) send_request(OP_ALLOC, $urandom_range(1, 64), 0, 0);
    for (int i = 0; i < 8; i++) send_request(OP_FREE, 0, 0, pick_address());
    send_request(OP_ALLOC, 32'd100000, 0, 0);
    send_request(OP_ALLOC, 1, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int unsigned count);
    logic [1:0] op;
    for (int unsigned i = 0; i < count; i++) begin
      op = 2'($urandom_range(0, 3));
      case (op)
        OP_ALLOC: send_request(op, pick_size(), $urandom, $urandom);
        OP_CALLOC: send_request(op, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64),
                                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64),
                                $urandom);
        OP_FREE: send_request(op, $urandom, $urandom, pick_address());
        default: send_request(op, pick_size(), $urandom, pick_address());
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    hold_rx = 1'b1;
    for (int i = 0; i < 6; i++) send_request(OP_ALLOC, $urandom_range(1, 32), 0, 0);
    wait_drained();
  endtask

  // Receiver stall: random bursts, or one long hold-off counted here.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_rx = 1'b0;
        out_stall_i <= 1'b0;
      end else if (rx_random_stall && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker.
  initial begin
    heap_result_t got, want;
    mismatches = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{ret_address_o, ok_o, num_free_blocks_o, num_free_bytes_o,
                num_alloc_blocks_o, num_alloc_bytes_o, num_meta_bytes_o};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("** first_fit_block_allocator_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_ALLOC;
    req_size_i = '0;
    elem_count_i = '0;
    old_address_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_HEAP_BASE;
    cfg_data_i = '0;
    rx_random_stall = 1'b1;
    tx_random_gap = 1'b1;
    hold_rx = 1'b0;
    base_reg = HEAP_BASE_RST;
    limit_reg = HEAP_LIMIT_RST;
    top_addr = HEAP_BASE_RST;
    n_blocks = 0;
    n_free = 0;
    free_total = 0;
    alloc_bytes = 0;
    meta_bytes = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_backpressure();
    test_random(300);
    test_fill_table();
    write_reg(REG_HEAP_LIMIT, $urandom_range(0, 1) ? 32'h0100_0000 : 32'h8000_0000);
    test_random(300);
    rx_random_stall = 1'b0;
    tx_random_gap = 1'b0;
    test_random(200);
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** first_fit_block_allocator_core: PASSED **");
    else
      $display("** first_fit_block_allocator_core: FAILED **");
    $finish;
  end
endmodule
